/* rtl/calscl_pkg.sv */
package calscl_pkg;

    localparam int SAMPLE_BITS_DEF = 13;

    // Datapath widths, sized for the widest sample (16 bits).
    localparam int X_W = 21;          // working value
    localparam int A_W = X_W;         // multiplicand
    localparam int B_W = 18;          // multiplier
    localparam int D_W = 18;          // divisor
    localparam int P_W = A_W + B_W;   // product / quotient
    localparam int OUT_W = 16;

    localparam int UNI_MAX = 16379;
    localparam int TOP_VAL = 16383;
    localparam int BOT_VAL = -16384;

    localparam logic [1:0] ACT_CONVERT = 2'd0;
    localparam logic [1:0] ACT_CAPTURE = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;
    localparam logic [1:0] ACT_FLAG    = 2'd3;

    localparam logic [1:0] PT_LOW  = 2'd0;
    localparam logic [1:0] PT_MID  = 2'd1;
    localparam logic [1:0] PT_HIGH = 2'd2;

    localparam logic [1:0] CFG_BIPOLAR = 2'd0;
    localparam logic [1:0] CFG_TOP     = 2'd1;
    localparam logic [1:0] CFG_BOTTOM  = 2'd2;

    typedef logic signed [X_W-1:0]   xval_t;
    typedef logic signed [P_W:0]     wide_t;
    typedef logic signed [OUT_W-1:0] oval_t;

    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [D_W-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [P_W-1:0] q;
    } md_rsp_t;

    function automatic oval_t sat16(input wide_t v);
        oval_t r;
        if (v > 32767) begin
            r = 16'sh7fff;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    function automatic xval_t clamp_cal(input wide_t v);
        xval_t r;
        if (v > TOP_VAL) begin
            r = X_W'(TOP_VAL);
        end else if (v < BOT_VAL) begin
            r = X_W'(BOT_VAL);
        end else begin
            r = X_W'(v);
        end
        return r;
    endfunction

endpackage

/* rtl/calscl_muldiv.sv */
module calscl_muldiv (
    input  logic                aclk,
    input  logic                aresetn,
    input  calscl_pkg::md_req_t req,
    output calscl_pkg::md_rsp_t rsp
);

    localparam int P_W   = calscl_pkg::P_W;
    localparam int D_W   = calscl_pkg::D_W;
    localparam int CNT_W = $clog2(P_W + 1);

    typedef enum logic [1:0] {MD_IDLE, MD_PREP, MD_DIV, MD_FIN} md_state_t;

    md_state_t             state_reg, state_next;
    logic signed [P_W-1:0] prod_reg, prod_next;
    logic signed [D_W-1:0] den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic [D_W-1:0]        rem_reg, rem_next;
    logic [D_W-1:0]        dmag_reg, dmag_next;
    logic [P_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic signed [P_W-1:0] q_reg, q_next;

    logic [D_W:0]          rem_sh;
    logic [D_W:0]          rem_sub;

    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        q_next     = q_reg;
        rem_sh     = {rem_reg, quo_reg[P_W-1]};
        rem_sub    = rem_sh - {1'b0, dmag_reg};
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    prod_next  = P_W'(req.a * req.b);
                    den_next   = req.d;
                    state_next = MD_PREP;
                end
            end
            MD_PREP: begin
                neg_next   = prod_reg[P_W-1] ^ den_reg[D_W-1];
                quo_next   = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
                dmag_next  = den_reg[D_W-1] ? D_W'(-den_reg) : D_W'(den_reg);
                rem_next   = '0;
                cnt_next   = CNT_W'(P_W);
                state_next = MD_DIV;
            end
            MD_DIV: begin
                if (rem_sh >= {1'b0, dmag_reg}) begin
                    rem_next = rem_sub[D_W-1:0];
                    quo_next = {quo_reg[P_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[D_W-1:0];
                    quo_next = {quo_reg[P_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = MD_FIN;
                end
            end
            MD_FIN: begin
                q_next     = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                done_next  = 1'b1;
                state_next = MD_IDLE;
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        prod_reg <= prod_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

/* rtl/calibrated_adc_scaler.sv */
// Converts a smoothed converter sample into a signed 16-bit control value:
// unipolar rescale or bipolar inversion, optional three-point calibration,
// optional map onto range_bottom..range_top. Capture, load and flag
// transactions complete in the cycle they are accepted. A convert
// transaction runs its linear maps one after another through a single
// multiply/divide unit whose divider retires one quotient bit per cycle.
// The number of maps run depends on mode, calibration and range. s_tready
// is low while a conversion runs; a finished result waits in the output
// register without blocking the next transaction.
module calibrated_adc_scaler #(
    parameter int SAMPLE_BITS = calscl_pkg::SAMPLE_BITS_DEF,
    parameter int S_TDATA_W   = ((SAMPLE_BITS + 19 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_index,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample, point_select, point_value, enable_flag, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scaled_value
    output logic [15:0]          m_tdata
);

    localparam int X_W   = calscl_pkg::X_W;
    localparam int A_W   = calscl_pkg::A_W;
    localparam int B_W   = calscl_pkg::B_W;
    localparam int D_W   = calscl_pkg::D_W;
    localparam int P_W   = calscl_pkg::P_W;
    localparam int OFF_SEL  = SAMPLE_BITS;
    localparam int OFF_PVAL = SAMPLE_BITS + 2;
    localparam int OFF_FLAG = SAMPLE_BITS + 18;

    typedef enum logic [2:0] {
        ST_IDLE, ST_UNI, ST_CAL_START, ST_CAL, ST_RNG_START, ST_RNG, ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  bipolar_reg, bipolar_next;
    logic signed [15:0]    top_reg, top_next;
    logic signed [15:0]    bottom_reg, bottom_next;
    logic signed [15:0]    low_reg, low_next;
    logic signed [15:0]    mid_reg, mid_next;
    logic signed [15:0]    high_reg, high_next;
    logic                  cal_act_reg, cal_act_next;
    calscl_pkg::xval_t     x_reg, x_next;
    logic signed [15:0]    out_lo_reg, out_lo_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    calscl_pkg::oval_t     m_tdata_reg, m_tdata_next;
    calscl_pkg::md_req_t   md_req_reg, md_req_next;
    calscl_pkg::md_rsp_t   md_rsp;

    logic [1:0]            in_action;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [1:0]            in_sel;
    logic signed [15:0]    in_pval;
    logic                  in_flag;
    logic                  s_accept;
    calscl_pkg::xval_t     s_ext;
    calscl_pkg::xval_t     shaped;
    calscl_pkg::xval_t     uni_clamped;
    calscl_pkg::oval_t     shaped_sat;
    calscl_pkg::xval_t     low_x, mid_x, high_x;
    calscl_pkg::xval_t     base_lo;
    calscl_pkg::xval_t     xq;
    logic signed [D_W-1:0] span_up, span_dn;
    logic                  rng_needed;

    assign in_action = s_tuser;
    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_sel    = s_tdata[OFF_SEL +: 2];
    assign in_pval   = s_tdata[OFF_PVAL +: 16];
    assign in_flag   = s_tdata[OFF_FLAG];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        s_ext       = {{(X_W - SAMPLE_BITS){1'b0}}, in_sample};
        shaped      = bipolar_reg ? (X_W'(calscl_pkg::TOP_VAL) - (s_ext <<< 2))
                                  : (s_ext <<< 1);
        uni_clamped = (s_ext > calscl_pkg::UNI_MAX) ? X_W'(calscl_pkg::UNI_MAX) : s_ext;
        shaped_sat  = calscl_pkg::sat16((P_W+1)'(shaped));
        low_x       = X_W'(low_reg);
        mid_x       = X_W'(mid_reg);
        high_x      = X_W'(high_reg);
        span_up     = D_W'(high_x - mid_x);
        span_dn     = D_W'(mid_x - low_x);
        base_lo     = bipolar_reg ? X_W'(calscl_pkg::BOT_VAL) : '0;
        rng_needed  = (top_reg != 16'sd16383) || (X_W'(bottom_reg) != base_lo);
        xq          = X_W'(md_rsp.q);
    end

    always_comb begin
        state_next    = state_reg;
        bipolar_next  = bipolar_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        low_next      = low_reg;
        mid_next      = mid_reg;
        high_next     = high_reg;
        cal_act_next  = cal_act_reg;
        x_next        = x_reg;
        out_lo_next   = out_lo_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        md_req_next   = md_req_reg;
        md_req_next.start = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                calscl_pkg::CFG_BIPOLAR: bipolar_next = cfg_wr_data[0];
                calscl_pkg::CFG_TOP:     top_next     = cfg_wr_data;
                calscl_pkg::CFG_BOTTOM:  bottom_next  = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_action)
                        calscl_pkg::ACT_CAPTURE: begin
                            cal_act_next = 1'b1;
                            case (in_sel)
                                calscl_pkg::PT_LOW:  low_next  = shaped_sat;
                                calscl_pkg::PT_MID:  mid_next  = shaped_sat;
                                calscl_pkg::PT_HIGH: high_next = shaped_sat;
                                default: ;
                            endcase
                        end
                        calscl_pkg::ACT_LOAD: begin
                            case (in_sel)
                                calscl_pkg::PT_LOW:  low_next  = in_pval;
                                calscl_pkg::PT_MID:  mid_next  = in_pval;
                                calscl_pkg::PT_HIGH: high_next = in_pval;
                                default: ;
                            endcase
                        end
                        calscl_pkg::ACT_FLAG: begin
                            cal_act_next = in_flag;
                        end
                        default: begin
                            if (bipolar_reg) begin
                                x_next     = shaped;
                                state_next = ST_CAL_START;
                            end else begin
                                md_req_next.start = 1'b1;
                                md_req_next.a     = A_W'(uni_clamped);
                                md_req_next.b     = B_W'(calscl_pkg::TOP_VAL);
                                md_req_next.d     = D_W'(calscl_pkg::UNI_MAX);
                                state_next        = ST_UNI;
                            end
                        end
                    endcase
                end
            end
            ST_UNI: begin
                if (md_rsp.done) begin
                    x_next     = xq <<< 1;
                    state_next = ST_CAL_START;
                end
            end
            ST_CAL_START: begin
                if (!cal_act_reg) begin
                    state_next = ST_RNG_START;
                end else if (x_reg >= mid_x) begin
                    if (span_up == '0) begin
                        x_next     = '0;
                        state_next = ST_RNG_START;
                    end else begin
                        md_req_next.start = 1'b1;
                        md_req_next.a     = A_W'(x_reg - mid_x);
                        md_req_next.b     = B_W'(calscl_pkg::TOP_VAL);
                        md_req_next.d     = span_up;
                        out_lo_next       = '0;
                        state_next        = ST_CAL;
                    end
                end else begin
                    if (span_dn == '0) begin
                        x_next     = X_W'(calscl_pkg::BOT_VAL);
                        state_next = ST_RNG_START;
                    end else begin
                        md_req_next.start = 1'b1;
                        md_req_next.a     = A_W'(x_reg - low_x);
                        md_req_next.b     = B_W'(-calscl_pkg::BOT_VAL);
                        md_req_next.d     = span_dn;
                        out_lo_next       = 16'(calscl_pkg::BOT_VAL);
                        state_next        = ST_CAL;
                    end
                end
            end
            ST_CAL: begin
                if (md_rsp.done) begin
                    x_next = calscl_pkg::clamp_cal((P_W+1)'(md_rsp.q)
                                                   + (P_W+1)'(out_lo_reg));
                    state_next = ST_RNG_START;
                end
            end
            ST_RNG_START: begin
                if (rng_needed) begin
                    md_req_next.start = 1'b1;
                    md_req_next.a     = A_W'(x_reg - base_lo);
                    md_req_next.b     = B_W'(B_W'(top_reg) - B_W'(bottom_reg));
                    md_req_next.d     = D_W'(X_W'(calscl_pkg::TOP_VAL) - base_lo);
                    state_next        = ST_RNG;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RNG: begin
                if (md_rsp.done) begin
                    x_next = X_W'(calscl_pkg::sat16((P_W+1)'(md_rsp.q)
                                                    + (P_W+1)'(bottom_reg)));
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = calscl_pkg::sat16((P_W+1)'(x_reg));
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            bipolar_reg       <= 1'b0;
            top_reg           <= 16'sd16383;
            bottom_reg        <= '0;
            low_reg           <= 16'(calscl_pkg::BOT_VAL);
            mid_reg           <= '0;
            high_reg          <= 16'(calscl_pkg::TOP_VAL);
            cal_act_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            md_req_reg.start  <= 1'b0;
        end else begin
            state_reg         <= state_next;
            bipolar_reg       <= bipolar_next;
            top_reg           <= top_next;
            bottom_reg        <= bottom_next;
            low_reg           <= low_next;
            mid_reg           <= mid_next;
            high_reg          <= high_next;
            cal_act_reg       <= cal_act_next;
            m_tvalid_reg      <= m_tvalid_next;
            md_req_reg.start  <= md_req_next.start;
        end
        x_reg        <= x_next;
        out_lo_reg   <= out_lo_next;
        m_tdata_reg  <= m_tdata_next;
        md_req_reg.a <= md_req_next.a;
        md_req_reg.b <= md_req_next.b;
        md_req_reg.d <= md_req_next.d;
    end

    calscl_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req_reg),
        .rsp     (md_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
